// File: rtl/quantized_dot_product_requant_assert.svh
// Assertion macros shared by the dot-product neuron RTL.
`ifndef QUANTIZED_DOT_PRODUCT_REQUANT_ASSERT_SVH
`define QUANTIZED_DOT_PRODUCT_REQUANT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QDPR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QDPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/qdpr_pkg.sv
// Shared constants and types of the quantized dot-product neuron.
package qdpr_pkg;

	localparam int unsigned ACC_BITS_DEF = 32;
	localparam int unsigned LANES        = 4;
	localparam int unsigned PHYS_LANES   = 4;
	localparam int unsigned LANE_LIMIT   = (LANES < PHYS_LANES) ? LANES : PHYS_LANES;

	localparam int unsigned ACT_W      = 8;
	localparam int unsigned WT_W       = 8;
	localparam int unsigned CNT_W      = 3;
	localparam int unsigned BN_W       = 32;
	localparam int unsigned OUT_W      = 8;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned SHIFT_W    = 5;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [OUT_W-1:0] BYTE_MAX = 8'd255;

	// quant_mode codes; the spare code behaves like MODE_SHIFT
	localparam logic [MODE_W-1:0] MODE_SHIFT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GAIN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BN    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_QUANT_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_GAIN  = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1;

	typedef logic [ACT_W-1:0]        act_t;
	typedef logic signed [WT_W-1:0]  wt_t;

	typedef struct packed {
		logic [MODE_W-1:0]  quant_mode;
		logic [SHIFT_W-1:0] result_shift;
		logic [GAIN_W-1:0]  result_gain;
	} cfg_t;

endpackage

// File: rtl/qdpr_operand_if.sv
// Input channel: one beat carries four activation/weight lanes and requant operands.
interface qdpr_operand_if import qdpr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	act_t                    act_a;
	act_t                    act_b;
	act_t                    act_c;
	act_t                    act_d;
	wt_t                     wt_a;
	wt_t                     wt_b;
	wt_t                     wt_c;
	wt_t                     wt_d;
	logic [CNT_W-1:0]        lane_count;
	logic signed [BN_W-1:0]  bn_scale;
	logic signed [BN_W-1:0]  bn_offset;
	logic                    last_element;

	modport source (
		output valid, act_a, act_b, act_c, act_d, wt_a, wt_b, wt_c, wt_d,
		output lane_count, bn_scale, bn_offset, last_element,
		input  ready
	);

	modport sink (
		input  valid, act_a, act_b, act_c, act_d, wt_a, wt_b, wt_c, wt_d,
		input  lane_count, bn_scale, bn_offset, last_element,
		output ready
	);
endinterface

// File: rtl/qdpr_result_if.sv
// Output channel: one beat carries the requantized neuron byte.
interface qdpr_result_if import qdpr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] neuron_out;

	modport source (output valid, neuron_out, input ready);
	modport sink   (input valid, neuron_out, output ready);
endinterface

// File: rtl/quantized_dot_product_requant.sv
// Quantized dot-product neuron: takes one beat per cycle (four activation/weight
// lanes each) unless a last beat waits on the requant pipeline, accumulating into
// an ACC_BITS-bit wrapping sum; on the beat marked last it emits one unsigned byte
// requantized by quant_mode and clears the sum. Beats stream back to back, as the
// accumulate loop closes combinationally; results pass through operand-select,
// product, offset-add and shift/clip stages, each stalling only when the one after
// it is full. The user must write registers via cfg_wr_en / cfg_index / cfg_wdata
// only while no neuron is in flight; the block does not enforce this.
module quantized_dot_product_requant import qdpr_pkg::*; #(
	parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qdpr_operand_if.sink          operand,
	qdpr_result_if.source         result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t                   cfg_q;
	logic                   tot_valid;
	logic                   tot_ready;
	logic [ACC_BITS-1:0]    tot_sum;
	logic signed [BN_W-1:0] tot_scale;
	logic signed [BN_W-1:0] tot_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quant_mode   <= MODE_SHIFT;
			cfg_q.result_shift <= '0;
			cfg_q.result_gain  <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUANT_MODE:   cfg_q.quant_mode   <= cfg_wdata[MODE_W-1:0];
				REG_RESULT_SHIFT: cfg_q.result_shift <= cfg_wdata[SHIFT_W-1:0];
				REG_RESULT_GAIN:  cfg_q.result_gain  <= cfg_wdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	qdpr_mac #(
		.ACC_BITS(ACC_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.operand    (operand),
		.tot_valid  (tot_valid),
		.tot_ready  (tot_ready),
		.tot_sum    (tot_sum),
		.tot_scale  (tot_scale),
		.tot_offset (tot_offset)
	);

	qdpr_requant #(
		.ACC_BITS(ACC_BITS)
	) u_requant (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tot_valid  (tot_valid),
		.tot_ready  (tot_ready),
		.tot_sum    (tot_sum),
		.tot_scale  (tot_scale),
		.tot_offset (tot_offset),
		.result     (result)
	);

endmodule

// File: rtl/qdpr_mac.sv
// Input register and four-lane multiply-accumulate with wrapping accumulator.
`include "quantized_dot_product_requant_assert.svh"

module qdpr_mac import qdpr_pkg::*; #(
	parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	qdpr_operand_if.sink           operand,
	output logic                   tot_valid,
	input  logic                   tot_ready,
	output logic [ACC_BITS-1:0]    tot_sum,
	output logic signed [BN_W-1:0] tot_scale,
	output logic signed [BN_W-1:0] tot_offset
);

	localparam int unsigned PROD_W = ACT_W + WT_W + 1;
	localparam int unsigned DOT_W  = PROD_W + $clog2(PHYS_LANES);

	logic                   v_s1;
	act_t                   act_s1 [PHYS_LANES];
	wt_t                    wt_s1  [PHYS_LANES];
	logic [CNT_W-1:0]       cnt_s1;
	logic signed [BN_W-1:0] scale_s1;
	logic signed [BN_W-1:0] offset_s1;
	logic                   last_s1;

	logic [ACC_BITS-1:0]      acc_q;
	logic signed [PROD_W-1:0] prod [PHYS_LANES];
	logic signed [DOT_W-1:0]  dot;
	logic [ACC_BITS-1:0]      sum_c;
	logic                     s1_leave;
	logic                     accept;

	// a beat that is not last retires into the accumulator at once
	assign s1_leave      = v_s1 && (!last_s1 || tot_ready);
	assign operand.ready = !v_s1 || s1_leave;
	assign accept        = operand.valid && operand.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			acc_q <= '0;
		end else begin
			if (operand.ready) begin
				v_s1 <= operand.valid;
			end
			if (s1_leave) begin
				acc_q <= last_s1 ? '0 : sum_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1[0] <= operand.act_a;
			act_s1[1] <= operand.act_b;
			act_s1[2] <= operand.act_c;
			act_s1[3] <= operand.act_d;
			wt_s1[0]  <= operand.wt_a;
			wt_s1[1]  <= operand.wt_b;
			wt_s1[2]  <= operand.wt_c;
			wt_s1[3]  <= operand.wt_d;
			cnt_s1    <= operand.lane_count;
			scale_s1  <= operand.bn_scale;
			offset_s1 <= operand.bn_offset;
			last_s1   <= operand.last_element;
		end
	end

	for (genvar i = 0; i < PHYS_LANES; i++) begin : g_lane
		assign prod[i] = $signed({1'b0, act_s1[i]}) * wt_s1[i];
	end

	// lane count above the lane limit saturates
	always_comb begin
		dot = '0;
		for (int i = 0; i < PHYS_LANES; i++) begin
			if ((i < LANE_LIMIT) && (cnt_s1 > CNT_W'(i))) begin
				dot = dot + DOT_W'(prod[i]);
			end
		end
	end

	assign sum_c      = acc_q + ACC_BITS'(dot);
	assign tot_valid  = v_s1 && last_s1;
	assign tot_sum    = sum_c;
	assign tot_scale  = scale_s1;
	assign tot_offset = offset_s1;

	`QDPR_ASSERT_NEXT(a_acc_clear_after_last, s1_leave && last_s1, acc_q == '0, "accumulator not cleared after last beat")

endmodule

// File: rtl/qdpr_requant.sv
// Requantization pipeline: operand select, split multiply, offset add, shift and clip.
`include "quantized_dot_product_requant_assert.svh"

module qdpr_requant import qdpr_pkg::*; #(
	parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   tot_valid,
	output logic                   tot_ready,
	input  logic [ACC_BITS-1:0]    tot_sum,
	input  logic signed [BN_W-1:0] tot_scale,
	input  logic signed [BN_W-1:0] tot_offset,
	qdpr_result_if.source          result
);

	localparam int unsigned LO_W = (ACC_BITS + 1) / 2;
	localparam int unsigned HI_W = ACC_BITS - LO_W;
	localparam int unsigned M_W  = BN_W + 1;

	logic                  v_s2, v_s3, v_s4, out_v_q;
	logic [ACC_BITS-1:0]   sum_s2;
	logic signed [M_W-1:0] m_s2;
	logic [ACC_BITS-1:0]   off_s2, off_s3;
	logic [ACC_BITS-1:0]   plo_s3;
	logic [HI_W-1:0]       phi_s3;
	logic [ACC_BITS-1:0]   val_s4;
	logic [OUT_W-1:0]      neuron_out_q;

	logic                  out_rdy, s4_rdy, s3_rdy, s2_rdy;
	logic signed [M_W-1:0] m_c;
	logic [ACC_BITS-1:0]   off_c;
	logic signed [M_W+LO_W:0]   plo_full;
	logic signed [M_W+HI_W-1:0] phi_full;
	logic [ACC_BITS-1:0]   shifted;
	logic [OUT_W-1:0]      clip_c;

	assign out_rdy   = !out_v_q || result.ready;
	assign s4_rdy    = !v_s4 || out_rdy;
	assign s3_rdy    = !v_s3 || s4_rdy;
	assign s2_rdy    = !v_s2 || s3_rdy;
	assign tot_ready = s2_rdy;

	// every mode is m * sum + offset; plain shift uses m = 1
	always_comb begin
		case (cfg.quant_mode)
			MODE_GAIN: begin
				m_c   = {{(M_W - GAIN_W){1'b0}}, cfg.result_gain};
				off_c = '0;
			end
			MODE_BN: begin
				m_c   = M_W'(tot_scale);
				off_c = ACC_BITS'(tot_offset);
			end
			default: begin
				m_c   = M_W'(1);
				off_c = '0;
			end
		endcase
	end

	// product mod 2^ACC_BITS from two narrow partial products
	assign plo_full = m_s2 * $signed({1'b0, sum_s2[LO_W-1:0]});
	assign phi_full = m_s2 * $signed(sum_s2[ACC_BITS-1:LO_W]);

	assign shifted = val_s4 >> cfg.result_shift;

	always_comb begin
		if (val_s4[ACC_BITS-1]) begin
			clip_c = '0;
		end else if (|shifted[ACC_BITS-1:OUT_W]) begin
			clip_c = BYTE_MAX;
		end else begin
			clip_c = shifted[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_rdy) begin
				v_s2 <= tot_valid;
			end
			if (s3_rdy) begin
				v_s3 <= v_s2;
			end
			if (s4_rdy) begin
				v_s4 <= v_s3;
			end
			if (out_rdy) begin
				out_v_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy && tot_valid) begin
			sum_s2 <= tot_sum;
			m_s2   <= m_c;
			off_s2 <= off_c;
		end
		if (s3_rdy && v_s2) begin
			plo_s3 <= plo_full[ACC_BITS-1:0];
			phi_s3 <= phi_full[HI_W-1:0];
			off_s3 <= off_s2;
		end
		if (s4_rdy && v_s3) begin
			val_s4 <= plo_s3 + {phi_s3, {LO_W{1'b0}}} + off_s3;
		end
		if (out_rdy && v_s4) begin
			neuron_out_q <= clip_c;
		end
	end

	assign result.valid      = out_v_q;
	assign result.neuron_out = neuron_out_q;

	`QDPR_ASSERT_NEXT(a_negative_clips_zero, v_s4 && out_rdy && val_s4[ACC_BITS-1], result.neuron_out == '0, "negative value not clipped to zero")
	`QDPR_ASSERT_NEXT(a_s3_holds_on_stall, v_s3 && !s4_rdy, v_s3 && $stable(plo_s3) && $stable(phi_s3), "product stage lost data under stall")
	`QDPR_ASSERT_IMPL(a_out_from_s4, $rose(out_v_q), $past(v_s4), "result beat without a clip stage entry")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the quantized dot-product neuron with requantization.
`timescale 1ns / 100ps

module tb;
	import qdpr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned IDLE_GAP    = 8;
	localparam int unsigned DRAIN_WAIT  = 16;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_SHOWN   = 10;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

	typedef struct packed {
		act_t [PHYS_LANES-1:0]  acts;
		wt_t [PHYS_LANES-1:0]   wts;
		logic [CNT_W-1:0]       lane_count;
		logic signed [BN_W-1:0] bn_scale;
		logic signed [BN_W-1:0] bn_offset;
		logic                   last_element;
	} beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	qdpr_operand_if op_if();
	qdpr_result_if  res_if();

	quantized_dot_product_requant dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.operand   (op_if.sink),
		.result    (res_if.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [ACC_BITS_DEF-1:0] acc_model = '0;
	cfg_t                    cfg_model = '{quant_mode: MODE_SHIFT, result_shift: '0,
	                                       result_gain: GAIN_RESET};
	logic [OUT_W-1:0]        pending_bytes[$];

	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// sender pacing
	bit tx_bursty = 0;
	int burst_left = 0;

	// receiver pacing
	rx_style_t   rx_mode = RX_ALWAYS;
	logic [15:0] rx_mask = 16'h5A5B;
	logic [3:0]  rx_tick = '0;
	logic        rx_hold = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		if (rx_hold)
			res_if.ready <= 1'b0;
		else
			case (rx_mode)
				RX_ALWAYS: res_if.ready <= 1'b1;
				RX_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
				default:   res_if.ready <= rx_mask[rx_tick];
			endcase
	end

	function automatic logic [OUT_W-1:0] requantize(input logic [ACC_BITS_DEF-1:0] total,
			input logic signed [BN_W-1:0] scale, input logic signed [BN_W-1:0] offset);
		logic [ACC_BITS_DEF-1:0] v;
		logic [ACC_BITS_DEF-1:0] shifted;
		case (cfg_model.quant_mode)
			MODE_GAIN: v = total * {{(ACC_BITS_DEF-GAIN_W){1'b0}}, cfg_model.result_gain};
			MODE_BN:   v = total * scale + offset;
			default:   v = total;
		endcase
		// a negative value clips to zero before the shift is applied
		if (v[ACC_BITS_DEF-1])
			return '0;
		shifted = v >> cfg_model.result_shift;
		return (shifted > BYTE_MAX) ? BYTE_MAX : shifted[OUT_W-1:0];
	endfunction

	task automatic accumulate_beat();
		act_t                    a [PHYS_LANES];
		wt_t                     w [PHYS_LANES];
		logic signed [ACC_BITS_DEF-1:0] prod;
		int unsigned             n;
		a[0] = op_if.act_a; a[1] = op_if.act_b; a[2] = op_if.act_c; a[3] = op_if.act_d;
		w[0] = op_if.wt_a;  w[1] = op_if.wt_b;  w[2] = op_if.wt_c;  w[3] = op_if.wt_d;
		n = (op_if.lane_count > LANE_LIMIT) ? LANE_LIMIT : op_if.lane_count;
		for (int k = 0; k < n; k++) begin
			prod = $signed({1'b0, a[k]}) * w[k];
			acc_model = acc_model + prod;
		end
		if (op_if.last_element) begin
			pending_bytes.push_back(requantize(acc_model, op_if.bn_scale, op_if.bn_offset));
			acc_model = '0;
		end
	endtask

	always @(posedge clk)
		if (arst_n && op_if.valid && op_if.ready)
			accumulate_beat();

	task automatic flag_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("tb: mismatch at cycle %0d: %s expected %0d got %0d",
				cycles, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_bytes.size() == 0)
				flag_mismatch("unexpected beat, neuron_out", 0, res_if.neuron_out);
			else if (pending_bytes[0] !== res_if.neuron_out)
				flag_mismatch("neuron_out", pending_bytes[0], res_if.neuron_out);
			if (pending_bytes.size() != 0)
				void'(pending_bytes.pop_front());
		end
	end

	function automatic beat_t make_beat(input logic [31:0] acts, input logic [31:0] wts,
			input logic [CNT_W-1:0] lanes, input logic last,
			input logic [BN_W-1:0] scale, input logic [BN_W-1:0] offset);
		beat_t b;
		b.acts = acts;
		b.wts = wts;
		b.lane_count = lanes;
		b.last_element = last;
		b.bn_scale = scale;
		b.bn_offset = offset;
		return b;
	endfunction

	function automatic beat_t random_beat(input logic last);
		beat_t b;
		for (int k = 0; k < PHYS_LANES; k++) begin
			b.acts[k] = ACT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom);
			b.wts[k] = WT_W'($urandom);
			// lean toward positive weights so outputs are not mostly clipped to zero
			if ($urandom_range(0, 1))
				b.wts[k][WT_W-1] = 1'b0;
		end
		b.lane_count = CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
			: $urandom_range(1, 4));
		b.bn_scale = ($urandom_range(0, 3) == 0) ? $urandom : int'($urandom_range(0, 64)) - 32;
		b.bn_offset = ($urandom_range(0, 3) == 0) ? $urandom
			: int'($urandom_range(0, 8000)) - 2000;
		b.last_element = last;
		return b;
	endfunction

	// Called on a clock edge; returns at the edge that accepts the beat.
	task automatic send_beat(input beat_t b);
		int unsigned gap;
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					op_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		op_if.valid        <= 1'b1;
		op_if.act_a        <= b.acts[0];
		op_if.act_b        <= b.acts[1];
		op_if.act_c        <= b.acts[2];
		op_if.act_d        <= b.acts[3];
		op_if.wt_a         <= b.wts[0];
		op_if.wt_b         <= b.wts[1];
		op_if.wt_c         <= b.wts[2];
		op_if.wt_d         <= b.wts[3];
		op_if.lane_count   <= b.lane_count;
		op_if.bn_scale     <= b.bn_scale;
		op_if.bn_offset    <= b.bn_offset;
		op_if.last_element <= b.last_element;
		do
			@(posedge clk);
		while (!op_if.ready);
	endtask

	task automatic send_vector(input int unsigned len);
		for (int j = 0; j < len; j++)
			send_beat(random_beat(j == len - 1));
	endtask

	// all results in, plus margin for a beat that makes no result;
	// one edge first so the predictor has taken the beat accepted at this edge
	task automatic wait_idle();
		op_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_QUANT_MODE:   cfg_model.quant_mode = data[MODE_W-1:0];
			REG_RESULT_SHIFT: cfg_model.result_shift = data[SHIFT_W-1:0];
			REG_RESULT_GAIN:  cfg_model.result_gain = data[GAIN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// reset settings: lane extremes, zero and oversized lane counts, unknown register
	task automatic test_reset_state();
		send_beat(make_beat(32'h000000FF, 32'h0000007F, 3'd1, 1'b1, 0, 0));
		send_beat(make_beat(32'h000000FF, 32'h00000080, 3'd1, 1'b1, 0, 0));
		send_beat(make_beat(32'hFFFFFFFF, 32'h7F7F7F7F, 3'd0, 1'b1, 0, 0));
		send_beat(make_beat(32'h281E140A, 32'h03FF0201, 3'd4, 1'b1, 0, 0));
		send_beat(make_beat(32'h04030201, 32'h01010101, 3'd5, 1'b0, 0, 0));
		send_beat(make_beat(32'h04030201, 32'h01010101, 3'd6, 1'b0, 0, 0));
		send_beat(make_beat(32'h04030201, 32'h01010101, 3'd7, 1'b1, 0, 0));
		send_beat(make_beat(32'h80402010, 32'hF0100804, 3'd2, 1'b0, 0, 0));
		send_beat(make_beat(32'h80402010, 32'hF0100804, 3'd3, 1'b1, 0, 0));
		wait_idle();
		write_reg(CFG_IDX_W'(3), 16'hFFFF);
		send_beat(make_beat(32'h00000030, 32'h00000002, 3'd1, 1'b1, 0, 0));
		wait_idle();
	endtask

	task automatic test_register_extremes();
		// spare mode code and out-of-range data, masked by the block
		write_reg(REG_QUANT_MODE, 16'hFFFF);
		write_reg(REG_RESULT_SHIFT, 16'hFFE7);
		send_beat(make_beat(32'hFFFFFFFF, 32'h7F7F7F7F, 3'd4, 1'b1, 0, 0));
		send_beat(make_beat(32'h00000040, 32'h00000020, 3'd1, 1'b1, 0, 0));
		wait_idle();
		write_reg(REG_QUANT_MODE, {14'd0, MODE_GAIN});
		write_reg(REG_RESULT_SHIFT, 16'd0);
		write_reg(REG_RESULT_GAIN, 16'd0);
		send_beat(make_beat(32'h000000FF, 32'h0000007F, 3'd1, 1'b1, 0, 0));
		wait_idle();
		write_reg(REG_RESULT_GAIN, 16'hFFFF);
		send_beat(make_beat(32'h00000001, 32'h00000001, 3'd1, 1'b1, 0, 0));
		send_beat(make_beat(32'h00000001, 32'h000000FF, 3'd1, 1'b1, 0, 0));
		wait_idle();
		write_reg(REG_RESULT_SHIFT, 16'h001F);
		send_beat(make_beat(32'h000000FF, 32'h0000007F, 3'd1, 1'b1, 0, 0));
		wait_idle();
		write_reg(REG_QUANT_MODE, {14'd0, MODE_BN});
		write_reg(REG_RESULT_SHIFT, 16'd1);
		send_beat(make_beat(32'h00000001, 32'h00000001, 3'd1, 1'b1, 32'h80000000, 32'h7FFFFFFF));
		send_beat(make_beat(32'h00000032, 32'h00000001, 3'd1, 1'b1, 32'd2, 32'd100));
		send_beat(make_beat(32'h00000003, 32'h000000FF, 3'd1, 1'b1, -32'sd7, -32'sd1));
		send_beat(make_beat(32'h00000001, 32'h00000001, 3'd1, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF));
		wait_idle();
	endtask

	task automatic test_random_settings();
		int unsigned sent;
		int unsigned len;
		logic [MODE_W-1:0] mode;
		logic [SHIFT_W-1:0] shift;
		logic [GAIN_W-1:0] gain;
		for (int ph = 0; ph < 11; ph++) begin
			mode = MODE_W'($urandom_range(0, 3));
			shift = SHIFT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
				: $urandom_range(2, 12));
			gain = GAIN_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom);
			case (ph)
				0: begin mode = MODE_SHIFT; shift = '0; end
				1: begin mode = MODE_BN; shift = '1; end
				2: begin mode = MODE_GAIN; gain = '0; end
				3: begin mode = MODE_GAIN; gain = '1; shift = '1; end
				4: mode = MODE_BN;
				default: ;
			endcase
			write_reg(REG_QUANT_MODE, CFG_DATA_W'(mode));
			write_reg(REG_RESULT_SHIFT, CFG_DATA_W'(shift));
			write_reg(REG_RESULT_GAIN, gain);
			case (ph % 3)
				0: rx_mode <= RX_RANDOM;
				1: begin rx_mode <= RX_PATTERN; rx_mask <= 16'($urandom | 1); end
				default: rx_mode <= RX_ALWAYS;
			endcase
			tx_bursty = (ph % 4 != 3);
			sent = 0;
			while (sent < 125) begin
				len = $urandom_range(1, 10);
				send_vector(len);
				sent += len;
			end
			wait_idle();
		end
	endtask

	// sink held off while the source keeps pushing, so the pipeline backs up into the input
	task automatic test_output_backpressure();
		write_reg(REG_QUANT_MODE, {14'd0, MODE_SHIFT});
		write_reg(REG_RESULT_SHIFT, 16'd6);
		tx_bursty = 0;
		rx_mode <= RX_RANDOM;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
			for (int j = 0; j < 40; j++)
				send_vector($urandom_range(1, 3));
		join
		wait_idle();
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		res_if.ready       = 1'b0;
		op_if.valid        = 1'b0;
		op_if.act_a        = '0;
		op_if.act_b        = '0;
		op_if.act_c        = '0;
		op_if.act_d        = '0;
		op_if.wt_a         = '0;
		op_if.wt_b         = '0;
		op_if.wt_c         = '0;
		op_if.wt_d         = '0;
		op_if.lane_count   = '0;
		op_if.bn_scale     = '0;
		op_if.bn_offset    = '0;
		op_if.last_element = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_extremes();
		test_output_backpressure();
		test_random_settings();

		op_if.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
